/* hdl/lzssd_pkg.sv */
// Shared types and constants for the LZSS stream decoder.
`default_nettype none
package lzssd_pkg;

    localparam int WINDOW_SIZE = 4096;
    localparam int MAX_MATCH   = 18;
    localparam int RING_AW     = $clog2(WINDOW_SIZE);
    localparam int LEN_W       = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [RING_AW-1:0] INIT_POS  = RING_AW'(WINDOW_SIZE - MAX_MATCH);
    localparam logic [7:0]         FILL_BYTE = 8'h20;
    localparam logic [7:0]         ZERO_BYTE = 8'h00;

    typedef enum logic {
        CMD_LITERAL,
        CMD_PAIR
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [7:0]         lit;
        logic [RING_AW-1:0] pos;
        logic [LEN_W-1:0]   len;
    } t_cmd;

endpackage
`default_nettype wire

/* hdl/lzssd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lzssd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

/* hdl/lzssd_front.sv */
// Front end: flag tracking and token parsing into literal and pair requests.
`default_nettype none
module lzssd_front import lzssd_pkg::*; #(
    parameter int MIN_MATCH_BIAS = 2
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_full,
    output logic            o_push,
    output t_cmd            o_cmd
);

    localparam logic [LEN_W-1:0] LEN_ADD = LEN_W'(MIN_MATCH_BIAS + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_MATCH);

    logic [7:0]       r_flag_shift, n_flag_shift;
    logic [3:0]       r_flags_left, n_flags_left;
    logic             r_pair_pending, n_pair_pending;
    logic [7:0]       r_pair_low, n_pair_low;
    logic             accept;
    logic [LEN_W-1:0] len_sum;

    assign accept  = i_valid && !i_full;
    assign len_sum = LEN_W'(i_byte[3:0]) + LEN_ADD;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag_shift   <= '0;
            r_flags_left   <= '0;
            r_pair_pending <= 1'b0;
            r_pair_low     <= '0;
        end else begin
            r_flag_shift   <= n_flag_shift;
            r_flags_left   <= n_flags_left;
            r_pair_pending <= n_pair_pending;
            r_pair_low     <= n_pair_low;
        end
    end

    always_comb begin
        n_flag_shift   = r_flag_shift;
        n_flags_left   = r_flags_left;
        n_pair_pending = r_pair_pending;
        n_pair_low     = r_pair_low;
        o_push         = 1'b0;
        o_cmd.kind     = CMD_LITERAL;
        o_cmd.lit      = i_byte;
        o_cmd.pos      = {i_byte[7:4], r_pair_low};
        o_cmd.len      = (len_sum > LEN_MAX) ? LEN_MAX : len_sum;
        if (accept) begin
            if (r_flags_left == 4'd0) begin
                n_flag_shift = i_byte;
                n_flags_left = 4'd8;
            end else if (r_pair_pending) begin
                o_push         = 1'b1;
                o_cmd.kind     = CMD_PAIR;
                n_pair_pending = 1'b0;
                n_flag_shift   = {1'b0, r_flag_shift[7:1]};
                n_flags_left   = r_flags_left - 4'd1;
            end else if (r_flag_shift[0]) begin
                o_push       = 1'b1;
                n_flag_shift = {1'b0, r_flag_shift[7:1]};
                n_flags_left = r_flags_left - 4'd1;
            end else begin
                n_pair_low     = i_byte;
                n_pair_pending = 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* hdl/lzssd_queue.sv */
// Short request queue between the parser and the copy engine.
`default_nettype none
module lzssd_queue import lzssd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("request pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("request popped from an empty queue");

endmodule
`default_nettype wire

/* hdl/lzssd_back.sv */
// Back end: literal output, ring-window match copy and output register.
`default_nettype none
module lzssd_back import lzssd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    input  wire t_cmd i_q_cmd,
    output logic      o_pop,
    output logic       o_valid,
    input  wire logic  i_stall,
    output logic [7:0] o_byte,
    output logic       o_last
);

    logic               r_pend, n_pend;
    logic [RING_AW-1:0] r_src, n_src;
    logic [LEN_W-1:0]   r_left, n_left;
    logic [RING_AW-1:0] r_wpos, n_wpos;
    logic [RING_AW:0]   r_wcnt, n_wcnt;
    logic               r_sel_alt, n_sel_alt;
    logic [7:0]         r_alt_byte, n_alt_byte;

    logic               can_load;
    logic               load;
    logic [7:0]         load_byte;
    logic               load_last;
    logic               wr_en;
    logic [7:0]         wr_data;
    logic               rd_en;
    logic [RING_AW-1:0] rd_addr;
    logic [7:0]         ram_q;
    logic [7:0]         rd_data;
    logic [RING_AW-1:0] rd_offset;
    logic               rd_written;
    logic               rd_fwd;

    assign can_load  = !o_valid || !i_stall;
    assign rd_data   = r_sel_alt ? r_alt_byte : ram_q;
    assign rd_offset = rd_addr - INIT_POS;
    assign rd_written = r_wcnt[RING_AW] || ({1'b0, rd_offset} < r_wcnt);
    assign rd_fwd    = wr_en && (rd_addr == r_wpos);

    lzssd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_SIZE)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wpos),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_left  <= '0;
            r_wpos  <= INIT_POS;
            r_wcnt  <= '0;
            o_valid <= 1'b0;
        end else begin
            r_pend <= n_pend;
            r_left <= n_left;
            r_wpos <= n_wpos;
            r_wcnt <= n_wcnt;
            if (can_load) begin
                o_valid <= load;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_src      <= n_src;
        r_sel_alt  <= n_sel_alt;
        r_alt_byte <= n_alt_byte;
        if (load) begin
            o_byte <= load_byte;
            o_last <= load_last;
        end
    end

    always_comb begin
        n_pend     = r_pend;
        n_src      = r_src;
        n_left     = r_left;
        n_wpos     = r_wpos;
        n_wcnt     = r_wcnt;
        n_sel_alt  = r_sel_alt;
        n_alt_byte = r_alt_byte;
        load       = 1'b0;
        load_byte  = rd_data;
        load_last  = 1'b0;
        wr_en      = 1'b0;
        wr_data    = rd_data;
        rd_en      = 1'b0;
        rd_addr    = r_src;
        o_pop      = 1'b0;

        if (r_pend) begin
            if (can_load) begin
                load      = 1'b1;
                load_last = (r_left == LEN_W'(1));
                wr_en     = 1'b1;
                n_left    = r_left - 1'b1;
                if (r_left == LEN_W'(1)) begin
                    n_pend = 1'b0;
                end else begin
                    rd_en = 1'b1;
                    n_src = r_src + 1'b1;
                end
            end
        end else if (i_q_valid) begin
            if (i_q_cmd.kind == CMD_PAIR) begin
                o_pop   = 1'b1;
                rd_en   = 1'b1;
                rd_addr = i_q_cmd.pos;
                n_src   = i_q_cmd.pos + 1'b1;
                n_left  = i_q_cmd.len;
                n_pend  = 1'b1;
            end else if (can_load) begin
                o_pop     = 1'b1;
                load      = 1'b1;
                load_byte = i_q_cmd.lit;
                load_last = 1'b1;
                wr_en     = 1'b1;
                wr_data   = i_q_cmd.lit;
            end
        end

        if (rd_en) begin
            n_sel_alt  = rd_fwd || !rd_written;
            if (rd_fwd) begin
                n_alt_byte = wr_data;
            end else begin
                n_alt_byte = (rd_addr < INIT_POS) ? FILL_BYTE : ZERO_BYTE;
            end
        end

        if (wr_en) begin
            n_wpos = r_wpos + 1'b1;
            if (!r_wcnt[RING_AW]) begin
                n_wcnt = r_wcnt + 1'b1;
            end
        end
    end

    a_pend_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_left != '0))
        else $error("copy pending with no bytes left");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= LEN_W'(MAX_MATCH))
        else $error("copy length above maximum match");

    a_fill_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wcnt[RING_AW] |=> r_wcnt[RING_AW])
        else $error("window fill count went back");

endmodule
`default_nettype wire

/* hdl/lzss_stream_decoder_unit.sv */
// Top level of the LZSS stream decoder: parser, request queue, copy engine.
// Path: a literal reaches the output through the request queue and the output register,
// a match's first byte through the queue, the ring read register and the output register.
// Rate: flag and first pair bytes yield no request; the copy engine loads one literal
// a cycle and, for a match, does one ring read a cycle while the output is not stalled.
// Reset: synchronous; the ring needs no clearing pass, a fill count supplies
// the initial window contents for entries not yet written.
`default_nettype none
module lzss_stream_decoder_unit import lzssd_pkg::*; #(
    parameter int MIN_MATCH_BIAS = 2
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_in_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_run
);

    logic push;
    t_cmd push_cmd;
    logic q_full;
    logic q_valid;
    t_cmd q_cmd;
    logic pop;

    assign o_in_stall = q_full;

    lzssd_front #(
        .MIN_MATCH_BIAS (MIN_MATCH_BIAS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_byte  (i_in_byte),
        .i_full  (q_full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    lzssd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    lzssd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_pop     (pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_byte    (o_out_byte),
        .o_last    (o_last_of_run)
    );

endmodule
`default_nettype wire
